// ===== design/qapm_pkg.sv =====
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared widths, limits, register indexes and types for the quad attitude
// PD mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

    localparam int AngleW = 15;
    localparam int BaseW  = 15;
    localparam int GainW  = 12;
    localparam int MotorW = 15;
    localparam int TermW  = 20;   // Q.10 axis sum floored to whole counts
    localparam int MixW   = 23;   // base plus three terms, no wrap
    localparam int CfgIdxW = 3;

    localparam logic [MotorW-1:0] MOTOR_MAX = 15'd22300;
    localparam logic [MotorW-1:0] MOTOR_MIN = 15'd16000;

    localparam logic [BaseW-1:0] BASE_ONE_RST   = 15'd20700;
    localparam logic [BaseW-1:0] BASE_TWO_RST   = 15'd20850;
    localparam logic [BaseW-1:0] BASE_THREE_RST = 15'd20700;
    localparam logic [BaseW-1:0] BASE_FOUR_RST  = 15'd20870;
    localparam logic [GainW-1:0] TILT_KP_RST    = 12'd800;
    localparam logic [GainW-1:0] TILT_KD_RST    = 12'd80;
    localparam logic [GainW-1:0] YAW_KP_RST     = 12'd0;
    localparam logic [GainW-1:0] YAW_KD_RST     = 12'd0;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BASE_ONE   = 3'd0,
        REG_BASE_TWO   = 3'd1,
        REG_BASE_THREE = 3'd2,
        REG_BASE_FOUR  = 3'd3,
        REG_TILT_KP    = 3'd4,
        REG_TILT_KD    = 3'd5,
        REG_YAW_KP     = 3'd6,
        REG_YAW_KD     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TermW-1:0] roll;
        logic signed [TermW-1:0] pitch;
        logic signed [TermW-1:0] yaw;
    } axis_terms_t;

    typedef struct packed {
        logic [BaseW-1:0] one;
        logic [BaseW-1:0] two;
        logic [BaseW-1:0] three;
        logic [BaseW-1:0] four;
    } motor_bases_t;

endpackage

// ===== design/quad_attitude_pd_mixer_top.sv =====
// ----------------------------------------------------------------------------
// quad_attitude_pd_mixer_top
// PD attitude controller with X-quad motor mixer and saturation.
// ----------------------------------------------------------------------------
// One request (yaw, pitch, roll in Q9.6 degrees) yields one set of four motor
// counts, each within 16000..22300. The block takes a new request every cycle
// unless the consumer stalls with both stages full. The sample lands in an input
// register with the previous angles, and the three PD products, sums and mixer
// run combinationally into the result register. Throughput is one request per
// clock while the consumer does not stall, set by the combinational
// multiply-add of each axis. Previous angles are cleared at reset and advance
// on every accepted request. Write the configuration registers only while no
// request is in flight.
module quad_attitude_pd_mixer_top
    import qapm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [BaseW-1:0]          cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [AngleW-1:0]  s_yaw_angle,
    input  logic signed [AngleW-1:0]  s_pitch_angle,
    input  logic signed [AngleW-1:0]  s_roll_angle,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [MotorW-1:0]         m_motor_one,
    output logic [MotorW-1:0]         m_motor_two,
    output logic [MotorW-1:0]         m_motor_three,
    output logic [MotorW-1:0]         m_motor_four
);

    motor_bases_t      bases_reg;
    logic [GainW-1:0]  tilt_kp_reg, tilt_kd_reg, yaw_kp_reg, yaw_kd_reg;

    logic signed [AngleW-1:0] prev_yaw_reg, prev_pitch_reg, prev_roll_reg;

    logic                     in_valid_reg;
    logic signed [AngleW-1:0] yaw_reg, pitch_reg, roll_reg;
    logic signed [AngleW-1:0] hist_yaw_reg, hist_pitch_reg, hist_roll_reg;

    logic                     out_valid_reg;
    logic [MotorW-1:0]        motor_one_reg, motor_two_reg, motor_three_reg, motor_four_reg;

    logic                     out_ready;
    logic                     in_accept;
    axis_terms_t              terms;
    logic [MotorW-1:0]        mix_one, mix_two, mix_three, mix_four;

    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign in_accept = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bases_reg.one   <= BASE_ONE_RST;
            bases_reg.two   <= BASE_TWO_RST;
            bases_reg.three <= BASE_THREE_RST;
            bases_reg.four  <= BASE_FOUR_RST;
            tilt_kp_reg     <= TILT_KP_RST;
            tilt_kd_reg     <= TILT_KD_RST;
            yaw_kp_reg      <= YAW_KP_RST;
            yaw_kd_reg      <= YAW_KD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE_ONE:   bases_reg.one   <= cfg_wdata;
                REG_BASE_TWO:   bases_reg.two   <= cfg_wdata;
                REG_BASE_THREE: bases_reg.three <= cfg_wdata;
                REG_BASE_FOUR:  bases_reg.four  <= cfg_wdata;
                REG_TILT_KP:    tilt_kp_reg     <= cfg_wdata[GainW-1:0];
                REG_TILT_KD:    tilt_kd_reg     <= cfg_wdata[GainW-1:0];
                REG_YAW_KP:     yaw_kp_reg      <= cfg_wdata[GainW-1:0];
                REG_YAW_KD:     yaw_kd_reg      <= cfg_wdata[GainW-1:0];
                default: ;
            endcase
        end
    end

    // angle history: advance on every accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_yaw_reg   <= '0;
            prev_pitch_reg <= '0;
            prev_roll_reg  <= '0;
        end else if (in_accept) begin
            prev_yaw_reg   <= s_yaw_angle;
            prev_pitch_reg <= s_pitch_angle;
            prev_roll_reg  <= s_roll_angle;
        end
    end

    // input stage: capture the sample together with the angles before it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end else if (out_ready) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            yaw_reg        <= s_yaw_angle;
            pitch_reg      <= s_pitch_angle;
            roll_reg       <= s_roll_angle;
            hist_yaw_reg   <= prev_yaw_reg;
            hist_pitch_reg <= prev_pitch_reg;
            hist_roll_reg  <= prev_roll_reg;
        end
    end

    qapm_axis u_axis_yaw (
        .angle (yaw_reg),
        .prev  (hist_yaw_reg),
        .kp    (yaw_kp_reg),
        .kd    (yaw_kd_reg),
        .term  (terms.yaw)
    );

    qapm_axis u_axis_pitch (
        .angle (pitch_reg),
        .prev  (hist_pitch_reg),
        .kp    (tilt_kp_reg),
        .kd    (tilt_kd_reg),
        .term  (terms.pitch)
    );

    qapm_axis u_axis_roll (
        .angle (roll_reg),
        .prev  (hist_roll_reg),
        .kp    (tilt_kp_reg),
        .kd    (tilt_kd_reg),
        .term  (terms.roll)
    );

    qapm_mixer u_mixer (
        .terms       (terms),
        .bases       (bases_reg),
        .motor_one   (mix_one),
        .motor_two   (mix_two),
        .motor_three (mix_three),
        .motor_four  (mix_four)
    );

    // result stage: hold while the consumer stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            motor_one_reg   <= mix_one;
            motor_two_reg   <= mix_two;
            motor_three_reg <= mix_three;
            motor_four_reg  <= mix_four;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_motor_one   = motor_one_reg;
    assign m_motor_two   = motor_two_reg;
    assign m_motor_three = motor_three_reg;
    assign m_motor_four  = motor_four_reg;

    // every delivered count sits inside the motor range
    a_motor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_motor_one >= MOTOR_MIN && m_motor_one <= MOTOR_MAX &&
                     m_motor_two >= MOTOR_MIN && m_motor_two <= MOTOR_MAX &&
                     m_motor_three >= MOTOR_MIN && m_motor_three <= MOTOR_MAX &&
                     m_motor_four >= MOTOR_MIN && m_motor_four <= MOTOR_MAX))
        else $error("motor count out of range");

    // an accepted request becomes the history for the next one
    a_history: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (prev_yaw_reg == $past(s_yaw_angle) &&
                       prev_roll_reg == $past(s_roll_angle)))
        else $error("angle history not advanced");

    // a sample in the input stage moves on whenever the result side is free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> m_valid)
        else $error("input stage did not advance");

    // the input stage is refilled only when it drains or is empty
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_ready) |-> !s_ready)
        else $error("input stage overwritten");

endmodule

// ===== design/qapm_axis.sv =====
// ----------------------------------------------------------------------------
// qapm_axis
// PD term of one axis: floor((kp*angle + kd*(prev - angle)) / 1024).
// ----------------------------------------------------------------------------
module qapm_axis
    import qapm_pkg::*;
(
    input  logic signed [AngleW-1:0] angle,
    input  logic signed [AngleW-1:0] prev,
    input  logic        [GainW-1:0]  kp,
    input  logic        [GainW-1:0]  kd,
    output logic signed [TermW-1:0]  term
);

    logic signed [AngleW:0]   diff;
    logic signed [27:0]       prod_p;
    logic signed [28:0]       prod_d;
    logic signed [29:0]       sum;

    assign diff   = 16'(prev) - 16'(angle);
    assign prod_p = 28'($signed({1'b0, kp})) * 28'(angle);
    assign prod_d = 29'($signed({1'b0, kd})) * 29'(diff);
    assign sum    = 30'(prod_p) + 30'(prod_d);

    // dropping the low ten bits of a two's complement value floors it
    assign term = sum[29:10];

endmodule

// ===== design/qapm_mixer.sv =====
// ----------------------------------------------------------------------------
// qapm_mixer
// X-quad mixer: adds or subtracts the axis terms, with per-motor signs, to each
// motor base and saturates the count to the motor range.
// ----------------------------------------------------------------------------
module qapm_mixer
    import qapm_pkg::*;
(
    input  axis_terms_t       terms,
    input  motor_bases_t      bases,
    output logic [MotorW-1:0] motor_one,
    output logic [MotorW-1:0] motor_two,
    output logic [MotorW-1:0] motor_three,
    output logic [MotorW-1:0] motor_four
);

    logic signed [MixW-1:0] r, p, y;
    logic signed [MixW-1:0] mix_one, mix_two, mix_three, mix_four;

    function automatic logic [MotorW-1:0] sat(input logic signed [MixW-1:0] v);
        logic [MotorW-1:0] res;
        if (v > $signed({8'd0, MOTOR_MAX})) begin
            res = MOTOR_MAX;
        end else if (v < $signed({8'd0, MOTOR_MIN})) begin
            res = MOTOR_MIN;
        end else begin
            res = v[MotorW-1:0];
        end
        return res;
    endfunction

    assign r = MixW'(terms.roll);
    assign p = MixW'(terms.pitch);
    assign y = MixW'(terms.yaw);

    assign mix_one   = $signed({8'd0, bases.one})   - r + p - y;
    assign mix_two   = $signed({8'd0, bases.two})   - r - p + y;
    assign mix_three = $signed({8'd0, bases.three}) + r + p + y;
    assign mix_four  = $signed({8'd0, bases.four})  + r - p - y;

    assign motor_one   = sat(mix_one);
    assign motor_two   = sat(mix_two);
    assign motor_three = sat(mix_three);
    assign motor_four  = sat(mix_four);

endmodule
